// ===== hw/rtl/utfv_pkg.sv =====
// shared types and constants for the utf-8 style varint decoder
package utfv_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 21;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 2;

  // completion status codes
  typedef enum logic [StatW-1:0] {
    ST_OK          = 2'd0,
    ST_STRAY       = 2'd1,
    ST_OVERLONG    = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_t;

  // continuation counts of the three multi-byte code sizes
  localparam logic [CountW-1:0] CNT_NONE  = 2'd0;
  localparam logic [CountW-1:0] CNT_TWO   = 2'd1;
  localparam logic [CountW-1:0] CNT_THREE = 2'd2;
  localparam logic [CountW-1:0] CNT_FOUR  = 2'd3;

  // highest values that count as overlong for each code size
  localparam logic [ValueW-1:0] FLOOR_TWO   = 21'h00007F;
  localparam logic [ValueW-1:0] FLOOR_THREE = 21'h0007FF;
  localparam logic [ValueW-1:0] FLOOR_FOUR  = 21'h00FFFF;

  // decode state carried from byte to byte
  typedef struct packed {
    logic [ValueW-1:0] acc;
    logic [CountW-1:0] remaining;
    logic [CountW-1:0] code_len;
  } utfv_state_t;

  // result produced by one byte
  typedef struct packed {
    logic              vld;
    logic [ValueW-1:0] value;
    status_t           status;
  } utfv_result_t;

endpackage

// ===== hw/rtl/utfv_if.sv =====
// handshake channel interfaces for the byte input and the decoded result
interface utfv_in_if
  import utfv_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface utfv_out_if
  import utfv_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic [StatW-1:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== hw/rtl/utfv_step.sv =====
// one-byte decode step: next state and optional result from current state
module utfv_step
  import utfv_pkg::*;
(
  input  utfv_state_t      st,
  input  logic [ByteW-1:0] byte_in,
  output utfv_state_t      st_nxt,
  output utfv_result_t     res
);

  logic [ValueW-1:0] acc_shift;
  logic [ValueW-1:0] floor_v;

  assign acc_shift = {st.acc[ValueW-7:0], byte_in[5:0]};

  always_comb begin
    case (st.code_len)
      CNT_TWO:   floor_v = FLOOR_TWO;
      CNT_THREE: floor_v = FLOOR_THREE;
      default:   floor_v = FLOOR_FOUR;
    endcase
  end

  always_comb begin
    st_nxt     = st;
    res.vld    = 1'b0;
    res.value  = '0;
    res.status = ST_OK;
    if (st.remaining == CNT_NONE) begin
      // lead byte
      case (byte_in) inside
        [8'h00:8'h7F]: begin
          res.vld   = 1'b1;
          res.value = ValueW'(byte_in);
        end
        [8'h80:8'hBF]: begin
          res.vld    = 1'b1;
          res.status = ST_STRAY;
        end
        [8'hC0:8'hDF]: begin
          st_nxt.acc       = ValueW'(byte_in[4:0]);
          st_nxt.remaining = CNT_TWO;
          st_nxt.code_len  = CNT_TWO;
        end
        [8'hE0:8'hEF]: begin
          st_nxt.acc       = ValueW'(byte_in[3:0]);
          st_nxt.remaining = CNT_THREE;
          st_nxt.code_len  = CNT_THREE;
        end
        [8'hF0:8'hF7]: begin
          st_nxt.acc       = ValueW'(byte_in[2:0]);
          st_nxt.remaining = CNT_FOUR;
          st_nxt.code_len  = CNT_FOUR;
        end
        default: begin
          res.vld    = 1'b1;
          res.status = ST_UNSUPPORTED;
        end
      endcase
    end else begin
      // continuation, top bits ignored
      st_nxt.acc       = acc_shift;
      st_nxt.remaining = st.remaining - CountW'(1);
      if (st.remaining == CNT_TWO) begin
        st_nxt.acc      = '0;
        st_nxt.code_len = CNT_NONE;
        res.vld         = 1'b1;
        if (acc_shift <= floor_v) begin
          res.status = ST_OVERLONG;
        end else begin
          res.value = acc_shift;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/utf8_style_varint_decoder.sv =====
// top level of the utf-8 style varint decoder
//
//   channel   dir  ports                          beat carries
//   in_bus    in   valid ready in_byte            one byte of the stream
//   out_bus   out  valid ready value status       one decoded value
//
// one byte per cycle while out_bus does not stall; a byte that completes a
// code goes through the input register, then the result register
// the decode step is a few compares and a 6-bit shift between the two
// registers, so a new byte can enter every cycle
// rst_n is synchronous, active low; it empties both registers and clears
// the decode state
// when out_bus stalls, bytes that give no result still drain; a byte that
// gives a result waits in the input register and in_bus.ready drops
module utf8_style_varint_decoder
  import utfv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  utfv_in_if.sink     in_bus,
  utfv_out_if.source  out_bus
);

  // input register
  logic             s1_vld_r;
  logic [ByteW-1:0] s1_byte_r;

  // decode state across bytes of one code
  utfv_state_t  st_r;
  utfv_state_t  st_nxt;
  utfv_result_t res;

  // result register
  logic              out_vld_r;
  logic [ValueW-1:0] out_value_r;
  status_t           out_status_r;

  logic out_free;  // result register can take a new beat this cycle
  logic s1_go;     // byte in the input register is consumed
  logic in_rdy;

  utfv_step u_step (
    .st      (st_r),
    .byte_in (s1_byte_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  assign out_free = !out_vld_r || out_bus.ready;
  // a byte with no result never waits on the output side
  assign s1_go    = s1_vld_r && (!res.vld || out_free);
  assign in_rdy   = !s1_vld_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      st_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_rdy) begin
        s1_vld_r <= in_bus.valid;
      end
      if (s1_go) begin
        st_r <= st_nxt;
      end
      if (out_free) begin
        out_vld_r <= s1_vld_r && res.vld;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_rdy && in_bus.valid) begin
      s1_byte_r <= in_bus.in_byte;
    end
    if (out_free && s1_vld_r && res.vld) begin
      out_value_r  <= res.value;
      out_status_r <= res.status;
    end
  end

  assign in_bus.ready   = in_rdy;
  assign out_bus.valid  = out_vld_r;
  assign out_bus.value  = out_value_r;
  assign out_bus.status = out_status_r;

endmodule

// ===== hw/rtl/utfv_checker.sv =====
// port-level checks for the varint decoder, bound to the top level
module utfv_checker
  import utfv_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ValueW-1:0] out_value,
  input logic [StatW-1:0]  out_status
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != StatW'(ST_OK)) |-> out_value == '0)
    else $error("error result with nonzero value");

  // no result beat right after reset
  a_rst_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat offered after reset");

  // a free output side never blocks the input
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

endmodule

bind utf8_style_varint_decoder utfv_checker u_utfv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_value  (out_bus.value),
  .out_status (out_bus.status)
);

// ===== sim/utf8_style_varint_decoder_test.sv =====
// self-checking testbench for the utf-8 style varint decoder
module utf8_style_varint_decoder_test
  import utfv_pkg::*;
();

  // one expected decode: value and completion status
  typedef struct packed {
    logic [ValueW-1:0] value;
    status_t           status;
  } decoded_t;

  logic clk;
  logic rst_n;

  utfv_in_if  byte_ch ();
  utfv_out_if res_ch ();

  utf8_style_varint_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (byte_ch),
    .out_bus (res_ch)
  );

  // bytes still to be offered, and decodes still owed by the block
  logic [ByteW-1:0] pending_bytes [$];
  decoded_t         expected_codes [$];

  // decoder state as the predictor sees it
  logic [ValueW-1:0] pred_acc;
  logic [CountW-1:0] pred_remaining;
  logic [CountW-1:0] pred_code_len;

  // idle percentages for the sender and the receiver, set per phase
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  int unsigned mismatches = 0;
  int unsigned bytes_accepted = 0;
  int unsigned codes_ok = 0;
  int unsigned codes_failed = 0;

  // directed bytes: the extremes of every lead class, overlong edges,
  // unchecked continuation tops and a lead-looking byte inside a code
  logic [ByteW-1:0] directed_seq [26] = '{
    8'h00, 8'h7F,                   // single-byte extremes
    8'h80, 8'hBF,                   // stray continuation leads
    8'hF8, 8'hFF,                   // unsupported leads
    8'hC0, 8'h80,                   // two-byte zero, overlong
    8'hDF, 8'hBF,                   // two-byte max 0x7ff
    8'hE0, 8'h9F, 8'hBF,            // three-byte 0x7ff, overlong
    8'hEF, 8'hFF, 8'hFF,            // three-byte 0xffff, top bits ignored
    8'hF0, 8'h8F, 8'hBF, 8'hBF,     // four-byte 0xffff, overlong
    8'hF7, 8'hFF, 8'hFF, 8'hFF,     // four-byte all ones, 0x1fffff
    8'hC2, 8'h41                    // ascii-looking byte eaten as continuation
  };

  // clock: 8 time units, high then low
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic note_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // advance the predicted state by one accepted byte; queue a decode
  // whenever the byte closes a code or is rejected as a lead
  function automatic void predict_byte(input logic [ByteW-1:0] b);
    decoded_t          r;
    logic              have;
    logic [ValueW-1:0] floor_v;
    have = 1'b0;
    r.value = '0;
    r.status = ST_OK;
    if (pred_remaining == CNT_NONE) begin
      if (b <= 8'h7F) begin
        r.value = ValueW'(b);
        have = 1'b1;
      end else if (b <= 8'hBF) begin
        r.status = ST_STRAY;
        have = 1'b1;
      end else if (b <= 8'hDF) begin
        pred_acc = ValueW'(b[4:0]);
        pred_remaining = CNT_TWO;
      end else if (b <= 8'hEF) begin
        pred_acc = ValueW'(b[3:0]);
        pred_remaining = CNT_THREE;
      end else if (b <= 8'hF7) begin
        pred_acc = ValueW'(b[2:0]);
        pred_remaining = CNT_FOUR;
      end else begin
        r.status = ST_UNSUPPORTED;
        have = 1'b1;
      end
      if (!have) pred_code_len = pred_remaining;
    end else begin
      // any byte inside a code counts as a continuation, low six bits only
      pred_acc = {pred_acc[ValueW-7:0], b[5:0]};
      pred_remaining = pred_remaining - CountW'(1);
      if (pred_remaining == CNT_NONE) begin
        case (pred_code_len)
          CNT_TWO:   floor_v = FLOOR_TWO;
          CNT_THREE: floor_v = FLOOR_THREE;
          default:   floor_v = FLOOR_FOUR;
        endcase
        if (pred_acc <= floor_v) begin
          r.status = ST_OVERLONG;
        end else begin
          r.value = pred_acc;
        end
        have = 1'b1;
        pred_acc = '0;
        pred_code_len = CNT_NONE;
      end
    end
    if (have) expected_codes.push_back(r);
  endfunction

  // encode one value as an n-byte code; with noisy set the top two bits of
  // the continuation bytes are random, since the block ignores them
  function automatic void queue_code(input int unsigned nbytes, input logic [ValueW-1:0] v,
                                     input bit noisy);
    logic [1:0] top;
    top = noisy ? 2'($urandom) : 2'b10;
    case (nbytes)
      1: pending_bytes.push_back({1'b0, v[6:0]});
      2: begin
        pending_bytes.push_back({3'b110, v[10:6]});
        pending_bytes.push_back({top, v[5:0]});
      end
      3: begin
        pending_bytes.push_back({4'b1110, v[15:12]});
        pending_bytes.push_back({top, v[11:6]});
        top = noisy ? 2'($urandom) : 2'b10;
        pending_bytes.push_back({top, v[5:0]});
      end
      default: begin
        pending_bytes.push_back({5'b11110, v[20:18]});
        pending_bytes.push_back({top, v[17:12]});
        top = noisy ? 2'($urandom) : 2'b10;
        pending_bytes.push_back({top, v[11:6]});
        top = noisy ? 2'($urandom) : 2'b10;
        pending_bytes.push_back({top, v[5:0]});
      end
    endcase
  endfunction

  // mostly well-formed codes with random content; some overlong, some
  // stray or unsupported leads, and raw noise that breaks open codes
  task automatic queue_random_stream(input int unsigned nbytes);
    int unsigned start;
    int unsigned sel;
    bit          noisy;
    bit          short_val;
    start = pending_bytes.size();
    while (pending_bytes.size() - start < nbytes) begin
      sel = $urandom_range(99);
      noisy = ($urandom_range(3) == 0);
      short_val = ($urandom_range(6) == 0);
      if (sel < 20) begin
        queue_code(1, ValueW'($urandom_range(8'h7F)), 1'b0);
      end else if (sel < 40) begin
        queue_code(2, short_val ? ValueW'($urandom_range(8'h7F))
                                : ValueW'($urandom_range(11'h7FF, 8'h80)), noisy);
      end else if (sel < 60) begin
        queue_code(3, short_val ? ValueW'($urandom_range(11'h7FF))
                                : ValueW'($urandom_range(16'hFFFF, 12'h800)), noisy);
      end else if (sel < 78) begin
        queue_code(4, short_val ? ValueW'($urandom_range(16'hFFFF))
                                : ValueW'($urandom_range(21'h1FFFFF, 17'h10000)), noisy);
      end else if (sel < 86) begin
        pending_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
      end else if (sel < 92) begin
        pending_bytes.push_back(8'($urandom_range(8'hFF, 8'hF8)));
      end else begin
        pending_bytes.push_back(8'($urandom));
      end
    end
  endtask

  // wait until every queued byte went in and every owed decode came out
  task automatic drain_all();
    @(negedge clk);
    while (pending_bytes.size() != 0 || byte_ch.valid) @(negedge clk);
    while (expected_codes.size() != 0) @(negedge clk);
  endtask

  // byte driver: predict on each accepted beat, then offer the next byte
  // unless the sender idles this cycle
  always @(posedge clk) begin : byte_driver
    if (!rst_n) begin
      byte_ch.valid   <= 1'b0;
      byte_ch.in_byte <= '0;
      pred_acc        = '0;
      pred_remaining  = CNT_NONE;
      pred_code_len   = CNT_NONE;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        predict_byte(byte_ch.in_byte);
        bytes_accepted++;
      end
      // a beat on offer and not yet taken stays put
      if (!byte_ch.valid || byte_ch.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          byte_ch.valid   <= 1'b1;
          byte_ch.in_byte <= pending_bytes.pop_front();
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: check each beat against the oldest owed decode and
  // stall at random
  always @(posedge clk) begin : result_monitor
    decoded_t want;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_codes.size() == 0) begin
          note_mismatch($sformatf("unexpected result value %0h status %0d",
                                  res_ch.value, res_ch.status));
        end else begin
          want = expected_codes.pop_front();
          if (res_ch.value !== want.value)
            note_mismatch($sformatf("value %0h, predicted %0h", res_ch.value, want.value));
          if (res_ch.status !== want.status)
            note_mismatch($sformatf("status %0d, predicted %0d", res_ch.status, want.status));
          if (want.status == ST_OK) codes_ok++;
          else codes_failed++;
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // stimulus and end of run
  initial begin
    rst_n = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 73;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part, then the sender holds off until everything is back
    foreach (directed_seq[i]) pending_bytes.push_back(directed_seq[i]);
    drain_all();

    // sender light idle, receiver heavy stall
    queue_random_stream(140);
    drain_all();

    // sender heavy idle, receiver light stall
    send_idle_pct = 73;
    recv_idle_pct = 17;
    queue_random_stream(140);
    drain_all();

    // back to back at full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_stream(150);
    drain_all();

    // keep the clock running so a stray extra result would still show up
    repeat (20) @(posedge clk);

    $display("covered %0d bytes in three handshake regimes, %0d decodes ok, %0d error statuses",
             bytes_accepted, codes_ok, codes_failed);
    if (mismatches == 0) begin
      $display("utf8_style_varint_decoder: match");
    end else begin
      $display("utf8_style_varint_decoder: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1600000;
    $display("timeout: %0d decodes still owed", expected_codes.size());
    $display("utf8_style_varint_decoder: mismatch");
    $finish;
  end

endmodule
